### rtl/core/qsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qsm_pkg: shared types and constants for the QAM slicer / MER window
// Holds widths, per-mode tables and the front/back queue entry type.
// ----------------------------------------------------------------------------
package qsm_pkg;

  localparam int SampleBits = 16;
  localparam int AccBits    = 45;
  localparam int SumBits    = 52;
  localparam int SymBits    = 48;
  localparam int WindowMax  = 64;
  localparam int SlotBits   = 6;
  localparam int CountBits  = 7;

  localparam logic [AccBits-1:0] AccMax = {AccBits{1'b1}};
  localparam logic [SumBits-1:0] SumMax = {SumBits{1'b1}};

  typedef enum logic [2:0] {
    MOD_QPSK    = 3'd0,
    MOD_QAM16   = 3'd1,
    MOD_QAM64   = 3'd2,
    MOD_QAM256  = 3'd3,
    MOD_QAM1024 = 3'd4,
    MOD_QAM4096 = 3'd5
  } mod_t;

  localparam logic REG_MODULATION    = 1'b0;
  localparam logic REG_WINDOW_LENGTH = 1'b1;

  // One closed-or-open batch contribution between front and back.
  typedef struct packed {
    logic [AccBits-1:0] err_pow;
    logic [AccBits-1:0] ref_pow;
    logic               last;
  } pow_item_t;

  function automatic logic [17:0] root_q12(input logic [2:0] m);
    case (m)
      MOD_QPSK:    root_q12 = 18'd5793;
      MOD_QAM16:   root_q12 = 18'd12953;
      MOD_QAM64:   root_q12 = 18'd26545;
      MOD_QAM256:  root_q12 = 18'd53405;
      MOD_QAM1024: root_q12 = 18'd106968;
      default:     root_q12 = 18'd214014;
    endcase
  endfunction

  function automatic logic [11:0] scale_q12(input logic [2:0] m);
    case (m)
      MOD_QPSK:    scale_q12 = 12'd2896;
      MOD_QAM16:   scale_q12 = 12'd1295;
      MOD_QAM64:   scale_q12 = 12'd632;
      MOD_QAM256:  scale_q12 = 12'd314;
      MOD_QAM1024: scale_q12 = 12'd157;
      default:     scale_q12 = 12'd78;
    endcase
  endfunction

  function automatic logic [5:0] top_level(input logic [2:0] m);
    case (m)
      MOD_QPSK:    top_level = 6'd1;
      MOD_QAM16:   top_level = 6'd3;
      MOD_QAM64:   top_level = 6'd7;
      MOD_QAM256:  top_level = 6'd15;
      MOD_QAM1024: top_level = 6'd31;
      default:     top_level = 6'd63;
    endcase
  endfunction

endpackage
`default_nettype wire

### rtl/core/qam_slicer_mer_window.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qam_slicer_mer_window: QAM slicer with sliding-window MER sums
// Front slices symbols and forms powers; back accumulates batches and
// maintains a 64-slot sliding window of batch powers.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata {q,i}, tlast = last_of_batch
//  m_axis    out  tvalid/tready          tdata window results
//  cfg       in   cfg_we                 cfg_index, cfg_data
//
// A symbol that does not close a batch is added into the batch sums as it is
// taken; the slicer pipeline has four stages ahead of a four-entry queue.
// A closing symbol then steps through history read, subtract and add/write
// states, during which no symbol is taken; its result sits in an output
// register, and only the next closing symbol waits until that result is taken.
// Reset is synchronous and clears all control state; history slots are not
// cleared, a fill count marks unwritten slots so they read as zero.
// ----------------------------------------------------------------------------
module qam_slicer_mer_window (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [6:0]   cfg_data,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [31:0]  s_axis_tdata,   // i_sample[15:0], q_sample[31:16]
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [167:0]      m_axis_tdata    // err 52, ref 52, active 7, full,
                                            // valid, error_free, symbols 48
);
  import qsm_pkg::*;

  logic [2:0] modulation;
  logic [6:0] window_length;
  logic       f_valid, f_ready, q_valid, q_ready;
  pow_item_t  f_item, q_item;
  logic [51:0] we, wr;
  logic [6:0]  act;
  logic        full, est, ef;
  logic [47:0] sym;

  // Register file: hold settings until rewritten.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulation <= MOD_QPSK; window_length <= 7'd16;
    end else if (cfg_we) begin
      if (cfg_index == REG_MODULATION) modulation <= cfg_data[2:0];
      else window_length <= cfg_data;
    end
  end

  qsm_front u_front (
    .clk, .rst, .modulation,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .i_sample(s_axis_tdata[15:0]), .q_sample(s_axis_tdata[31:16]),
    .last_in(s_axis_tlast),
    .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item));

  qsm_fifo u_fifo (
    .clk, .rst, .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item));

  qsm_back u_back (
    .clk, .rst, .window_length,
    .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .window_error_power(we), .window_ref_power(wr), .active_batches(act),
    .window_full(full), .estimate_valid(est), .error_free(ef),
    .symbols_seen(sym));

  // Pad the 162 result bits up to whole bytes.
  assign m_axis_tdata = {6'd0, sym, ef, est, full, act, wr, we};

endmodule
`default_nettype wire

### rtl/core/qsm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qsm_front: symbol slicer pipeline
// Slices I and Q, forms error and ideal powers, feeds the queue.
// ----------------------------------------------------------------------------
module qsm_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [2:0]                   modulation,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [15:0]           i_sample,
  input  wire logic signed [15:0]           q_sample,
  input  wire logic                         last_in,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output qsm_pkg::pow_item_t                out_item
);
  import qsm_pkg::*;

  // stage 1: multiply by root
  logic               v1, v2, v3;
  logic signed [35:0] ti, tq;
  logic signed [15:0] x1i, x1q, x2i, x2q;
  logic [2:0]         m1, m2;
  logic               l1, l2, l3;
  logic signed [7:0]  lvi, lvq;
  logic signed [31:0] ei, eq, di, dq;
  logic [AccBits-1:0] errp, refp;

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  function automatic logic signed [7:0] decide(input logic signed [35:0] t,
                                               input logic [5:0] top);
    logic signed [37:0] u;
    logic signed [37:0] r;
    logic signed [37:0] lv;
    logic signed [37:0] tp;
    tp = 38'(top);
    u  = 38'(t) + (tp <<< 24);
    if (u >= 0) r = (u + 38'sd16777216) >>> 25;
    else        r = -((-u + 38'sd16777216) >>> 25);
    lv = 2 * r - tp;
    if (lv > tp)  lv = tp;
    if (lv < -tp) lv = -tp;
    decide = lv[7:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2;
    end
    if (adv) begin
      ti  <= 36'(i_sample * $signed({1'b0, root_q12(modulation)}));
      tq  <= 36'(q_sample * $signed({1'b0, root_q12(modulation)}));
      x1i <= i_sample; x1q <= q_sample;
      m1 <= (modulation > 3'd5) ? MOD_QAM4096 : modulation;
      l1 <= last_in;
      lvi <= decide(ti, top_level(m1));
      lvq <= decide(tq, top_level(m1));
      x2i <= x1i; x2q <= x1q; m2 <= m1; l2 <= l1;
      di  <= 32'(lvi * $signed({1'b0, scale_q12(m2)}));
      dq  <= 32'(lvq * $signed({1'b0, scale_q12(m2)}));
      ei  <= 32'(x2i) - 32'(lvi * $signed({1'b0, scale_q12(m2)}));
      eq  <= 32'(x2q) - 32'(lvq * $signed({1'b0, scale_q12(m2)}));
      l3  <= l2;
    end
  end

  always_comb begin
    errp = AccBits'(ei * ei) + AccBits'(eq * eq);
    refp = AccBits'(di * di) + AccBits'(dq * dq);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= v3;
    if (adv) begin
      out_item.err_pow <= errp;
      out_item.ref_pow <= refp;
      out_item.last    <= l3;
    end
  end

endmodule
`default_nettype wire

### rtl/core/qsm_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qsm_fifo: four-entry queue between slicer and window
// Decouples the slicer pipeline from the window update stalls.
// ----------------------------------------------------------------------------
module qsm_fifo (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr_valid,
  output logic                    wr_ready,
  input  wire qsm_pkg::pow_item_t wr_item,
  output logic                    rd_valid,
  input  wire logic               rd_ready,
  output qsm_pkg::pow_item_t      rd_item
);
  import qsm_pkg::*;

  pow_item_t  mem [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  logic       wr, rd;

  assign wr_ready = cnt != 3'd4;
  assign rd_valid = cnt != 3'd0;
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_item = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (wr) wp <= wp + 2'd1;
      if (rd) rp <= rp + 2'd1;
      cnt <= cnt + 3'(wr) - 3'(rd);
    end
    if (wr) mem[wp] <= wr_item;
  end

endmodule
`default_nettype wire

### rtl/core/qsm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qsm_back: batch accumulators and sliding window
// Sums powers per batch, rolls the window history on batch close.
// ----------------------------------------------------------------------------
module qsm_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [6:0]          window_length,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire qsm_pkg::pow_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [51:0]              window_error_power,
  output logic [51:0]              window_ref_power,
  output logic [6:0]               active_batches,
  output logic                     window_full,
  output logic                     estimate_valid,
  output logic                     error_free,
  output logic [47:0]              symbols_seen
);
  import qsm_pkg::*;

  typedef enum logic [3:0] {
    ST_ACC  = 4'b0001,
    ST_READ = 4'b0010,
    ST_SUB  = 4'b0100,
    ST_ADD  = 4'b1000
  } st_t;

  st_t                state;
  logic [AccBits-1:0] bacc_e, bacc_r, close_e, close_r;
  logic [AccBits-1:0] hist_e [WindowMax];
  logic [AccBits-1:0] hist_r [WindowMax];
  logic [AccBits-1:0] old_e, old_r;
  logic               old_ok;
  logic [SumBits-1:0] sum_e, sum_r;
  logic [SlotBits:0]  slot;
  logic [SlotBits:0]  fill;
  logic               wrapped;
  logic [CountBits-1:0] bcnt;
  logic [SymBits-1:0] symcnt;
  logic [6:0]         w;
  logic [AccBits:0]   ae, ar;
  logic [SumBits:0]   se, sr;
  logic [SlotBits:0]  p, pn;
  logic               hist_seen;
  logic [SumBits-1:0] sum_e_next, sum_r_next;
  logic [SlotBits:0]  slot_next;
  logic               wrapped_next;
  logic [CountBits-1:0] bcnt_next;

  assign w = (window_length == 7'd0) ? 7'd1 :
             (window_length > 7'(WindowMax)) ? 7'(WindowMax) : window_length;
  // A closing request waits for the previous result to be taken.
  assign in_ready = (state == ST_ACC) && !(out_valid && in_item.last);
  assign ae = {1'b0, bacc_e} + {1'b0, in_item.err_pow};
  assign ar = {1'b0, bacc_r} + {1'b0, in_item.ref_pow};
  assign se = {1'b0, sum_e} + SumBits'(close_e) + 1'b0;
  assign sr = {1'b0, sum_r} + SumBits'(close_r) + 1'b0;
  assign p  = (slot < 7'(WindowMax)) ? slot : '0;
  assign pn = p + 7'd1;
  // Slots at or above the fill count were never written and count as zero.
  assign hist_seen = wrapped && old_ok;

  assign sum_e_next   = se[SumBits] ? SumMax : se[SumBits-1:0];
  assign sum_r_next   = sr[SumBits] ? SumMax : sr[SumBits-1:0];
  assign slot_next    = (pn >= w) ? '0 : pn;
  assign wrapped_next = wrapped || (pn >= w);
  assign bcnt_next    = (bcnt < 7'(WindowMax)) ? bcnt + 7'd1 : bcnt;

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      old_e  <= hist_e[p[SlotBits-1:0]];
      old_r  <= hist_r[p[SlotBits-1:0]];
      old_ok <= p < fill;
    end
    if (state == ST_ADD) begin
      hist_e[p[SlotBits-1:0]] <= close_e;
      hist_r[p[SlotBits-1:0]] <= close_r;
    end
  end

  // Result register: hold the report while later requests accumulate.
  always_ff @(posedge clk) begin
    if (state == ST_ADD) begin
      window_error_power <= sum_e_next;
      window_ref_power   <= sum_r_next;
      active_batches     <= wrapped_next ? w : slot_next;
      window_full        <= wrapped_next;
      estimate_valid     <= bcnt_next >= (w >> 1);
      error_free         <= (sum_e_next == '0) && (sum_r_next != '0);
      symbols_seen       <= symcnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACC; bacc_e <= '0; bacc_r <= '0; sum_e <= '0; sum_r <= '0;
      slot <= '0; wrapped <= 1'b0; bcnt <= '0; symcnt <= '0; out_valid <= 1'b0;
      fill <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_ACC: begin
          if (in_valid && in_ready) begin
            symcnt <= symcnt + 48'd1;
            if (in_item.last) begin
              close_e <= ae[AccBits] ? AccMax : ae[AccBits-1:0];
              close_r <= ar[AccBits] ? AccMax : ar[AccBits-1:0];
              bacc_e <= '0; bacc_r <= '0;
              state <= ST_READ;
            end else begin
              bacc_e <= ae[AccBits] ? AccMax : ae[AccBits-1:0];
              bacc_r <= ar[AccBits] ? AccMax : ar[AccBits-1:0];
            end
          end
        end
        ST_READ: state <= ST_SUB;
        ST_SUB: begin
          if (hist_seen) begin
            sum_e <= (sum_e > SumBits'(old_e)) ? sum_e - SumBits'(old_e) : '0;
            sum_r <= (sum_r > SumBits'(old_r)) ? sum_r - SumBits'(old_r) : '0;
          end
          state <= ST_ADD;
        end
        ST_ADD: begin
          sum_e   <= sum_e_next;
          sum_r   <= sum_r_next;
          slot    <= slot_next;
          wrapped <= wrapped_next;
          bcnt    <= bcnt_next;
          if (p >= fill) fill <= pn;
          out_valid <= 1'b1;
          state <= ST_ACC;
        end
        default: state <= ST_ACC;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_ACC) |-> !in_ready) else $error("accept during window update");
  a_emit_after_add: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADD) |=> out_valid) else $error("missing result");
  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    slot <= 7'(WindowMax)) else $error("slot out of range");
  a_fill_prefix: assert property (@(posedge clk) disable iff (rst)
    slot <= fill) else $error("slot beyond written history");
endmodule
`default_nettype wire

### verif/qam_slicer_mer_window_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qam_slicer_mer_window_tb: self-checking bench for the QAM slicer MER window
// Drives symbol requests through the stream input and checks every closed
// batch result against an in-bench slicer and window model or a typed row,
// over several modulation and window settings, idle patterns and a long output stall.
// ----------------------------------------------------------------------------
module qam_slicer_mer_window_tb;
  import qsm_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam int SettleCycles = 40;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic         cfg_index;
  logic [6:0]   cfg_data;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata;   // i_sample[15:0], q_sample[31:16]
  logic         s_axis_tlast;   // last_of_batch
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [167:0] m_axis_tdata;   // err 52, ref 52, active 7, full, valid,
                                // error_free, symbols 48

  qam_slicer_mer_window uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // One window report as the block emits it.
  typedef struct {
    logic [51:0] err_sum;
    logic [51:0] ref_sum;
    logic [6:0]  active;
    logic        full;
    logic        valid;
    logic        clean;
    logic [47:0] symbols;
  } report_t;

  typedef struct {
    logic [15:0] i_s;
    logic [15:0] q_s;
    logic        last;
    logic        typed;
    report_t     rpt;
  } sym_row_t;

  // Grid tables, one entry per effective mode.
  longint grid_step [6] = '{2896, 1295, 632, 314, 157, 78};
  longint grid_inv  [6] = '{5793, 12953, 26545, 53405, 106968, 214014};
  longint grid_top  [6] = '{1, 3, 7, 15, 31, 63};

  // Model copy of the block state.
  logic [2:0]  mod_r;
  logic [6:0]  win_r;
  logic [63:0] batch_err, batch_ref;
  logic [63:0] err_hist [64];
  logic [63:0] ref_hist [64];
  logic [63:0] err_win, ref_win;
  int          slot;
  logic        wrapped;
  int          batches;
  logic [47:0] sym_count;

  report_t reports_due [$];
  int      fails;
  int      cycles;
  int      tx_idle, rx_idle;
  int      hold_left;
  bit      hold_req;
  int      sent;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Nearest odd level times the unit step, rounded half away from zero.
  function automatic longint slice_axis(longint x, int m);
    longint top, u, r, lvl;
    top = grid_top[m];
    u = x * grid_inv[m] + (top <<< 24);
    if (u >= 0) r = (u + (64'sd1 <<< 24)) / (64'sd1 <<< 25);
    else r = -((-u + (64'sd1 <<< 24)) / (64'sd1 <<< 25));
    lvl = 2 * r - top;
    if (lvl > top) lvl = top;
    if (lvl < -top) lvl = -top;
    return lvl * grid_step[m];
  endfunction

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b, logic [63:0] cap);
    logic [63:0] s;
    s = a + b;
    return (s > cap) ? cap : s;
  endfunction

  function automatic int eff_mode();
    return (mod_r > 3'd5) ? 5 : int'(mod_r);
  endfunction

  // Advance the window model by one symbol; return 1 when a report is due.
  function automatic bit window_advance(logic [15:0] i_s, logic [15:0] q_s, logic last,
                                        output report_t rpt);
    longint xi, xq, di, dq, ei, eq;
    int m, w;
    m = eff_mode();
    xi = longint'($signed(i_s));
    xq = longint'($signed(q_s));
    di = slice_axis(xi, m);
    dq = slice_axis(xq, m);
    ei = xi - di;
    eq = xq - dq;
    batch_err = sat_sum(batch_err, 64'(ei * ei + eq * eq), 64'(AccMax));
    batch_ref = sat_sum(batch_ref, 64'(di * di + dq * dq), 64'(AccMax));
    sym_count = sym_count + 48'd1;
    if (!last) return 0;
    w = (win_r == 0) ? 1 : (win_r > 7'd64) ? 64 : int'(win_r);
    if (slot >= 64) slot = 0;
    if (wrapped) begin
      err_win = (err_win > err_hist[slot]) ? err_win - err_hist[slot] : 64'd0;
      ref_win = (ref_win > ref_hist[slot]) ? ref_win - ref_hist[slot] : 64'd0;
    end
    err_hist[slot] = batch_err;
    ref_hist[slot] = batch_ref;
    err_win = sat_sum(err_win, batch_err, 64'(SumMax));
    ref_win = sat_sum(ref_win, batch_ref, 64'(SumMax));
    batch_err = 0;
    batch_ref = 0;
    slot = slot + 1;
    if (slot >= w) begin
      slot = 0;
      wrapped = 1'b1;
    end
    if (batches < 64) batches = batches + 1;
    rpt.err_sum = err_win[51:0];
    rpt.ref_sum = ref_win[51:0];
    rpt.active  = wrapped ? 7'(w) : 7'(slot);
    rpt.full    = wrapped;
    rpt.valid   = (batches >= w / 2);
    rpt.clean   = (err_win == 0) && (ref_win != 0);
    rpt.symbols = sym_count;
    return 1;
  endfunction

  // Offer one symbol request; hold it until the block takes it.
  task automatic send_symbol(logic [15:0] i_s, logic [15:0] q_s, logic last,
                             bit typed = 0, report_t typed_rpt = '{default: 0});
    report_t rpt;
    while ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {q_s, i_s};
    s_axis_tlast  <= last;
    // tready is stable at the falling edge: accept happens at the next rise
    forever begin
      @(negedge clk);
      if (s_axis_tready) break;
    end
    @(posedge clk);
    sent++;
    if (window_advance(i_s, q_s, last, rpt))
      reports_due.push_back(typed ? typed_rpt : rpt);
  endtask

  // Register writes only happen with the block drained.
  task automatic write_reg(logic idx, logic [6:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_MODULATION) mod_r = value[2:0];
    else win_r = value;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Near a grid point on one axis, or anywhere in range.
  function automatic logic [15:0] pick_axis(bit on_grid);
    int m, k;
    longint v;
    if (!on_grid) return 16'($urandom);
    m = eff_mode();
    k = 2 * $urandom_range(int'(grid_top[m]), 0) - int'(grid_top[m]);
    v = k * grid_step[m] + $urandom_range(48, 0) - 24;
    return 16'(v);
  endfunction

  // Receiver: random hold-off, plus one long stall on request.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_left = 600;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  // Compare each taken report with the oldest one due.
  always @(negedge clk) begin
    report_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (reports_due.size() == 0) begin
        $display("%0t: unexpected report, got %h", $time, m_axis_tdata);
        fails++;
      end else begin
        want = reports_due.pop_front();
        check_field("window_error_power", want.err_sum, m_axis_tdata[51:0]);
        check_field("window_ref_power", want.ref_sum, m_axis_tdata[103:52]);
        check_field("active_batches", want.active, m_axis_tdata[110:104]);
        check_field("window_full", want.full, m_axis_tdata[111]);
        check_field("estimate_valid", want.valid, m_axis_tdata[112]);
        check_field("error_free", want.clean, m_axis_tdata[113]);
        check_field("symbols_seen", want.symbols, m_axis_tdata[161:114]);
      end
    end
  end

  sym_row_t dir_tab [12];
  int win_plan [10] = '{1, 64, 0, 127, 5, 33, 2, 16, 100, 7};

  initial begin
    int n, len;
    bit grid;
    fails = 0; cycles = 0; sent = 0;
    tx_idle = 0; rx_idle = 0; hold_left = 0; hold_req = 0;
    mod_r = 3'd0; win_r = 7'd16;
    batch_err = 0; batch_ref = 0; err_win = 0; ref_win = 0;
    slot = 0; wrapped = 0; batches = 0; sym_count = 0;
    for (int k = 0; k < 64; k++) begin
      err_hist[k] = 0;
      ref_hist[k] = 0;
    end
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = REG_MODULATION; cfg_data = 7'd0;
    s_axis_tvalid = 1'b0; s_axis_tdata = 32'd0; s_axis_tlast = 1'b0;

    // Directed: reset settings, exact grid point, extremes, zero, ties.
    dir_tab[0]  = '{16'd2896, 16'd2896, 1'b1, 1'b1,
                    '{52'd0, 52'd16773632, 7'd1, 1'b0, 1'b0, 1'b1, 48'd1}};
    dir_tab[1]  = '{16'h8000, 16'h8000, 1'b0, 1'b0, '{default: 0}};
    dir_tab[2]  = '{16'h7fff, 16'h7fff, 1'b1, 1'b0, '{default: 0}};
    dir_tab[3]  = '{16'h0000, 16'h0000, 1'b1, 1'b0, '{default: 0}};
    dir_tab[4]  = '{16'h7fff, 16'h8000, 1'b0, 1'b0, '{default: 0}};
    dir_tab[5]  = '{16'h8000, 16'h7fff, 1'b0, 1'b0, '{default: 0}};
    dir_tab[6]  = '{16'hffff, 16'h0001, 1'b1, 1'b0, '{default: 0}};
    dir_tab[7]  = '{16'(-2896), 16'(-2896), 1'b1, 1'b0, '{default: 0}};
    dir_tab[8]  = '{16'h5555, 16'haaaa, 1'b0, 1'b0, '{default: 0}};
    dir_tab[9]  = '{16'haaaa, 16'h5555, 1'b1, 1'b0, '{default: 0}};
    dir_tab[10] = '{16'h1000, 16'hf000, 1'b0, 1'b0, '{default: 0}};
    dir_tab[11] = '{16'h0b50, 16'hf4b0, 1'b1, 1'b0, '{default: 0}};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[r])
      send_symbol(dir_tab[r].i_s, dir_tab[r].q_s, dir_tab[r].last,
                  dir_tab[r].typed, dir_tab[r].rpt);
    drain();

    // Fill every history slot once at the widest window before any shrink.
    write_reg(REG_WINDOW_LENGTH, 7'd64);
    for (int b = 0; b < 70; b++)
      send_symbol(pick_axis(1), pick_axis(1), 1'b1);
    drain();

    // Random phases: each sets both registers, then sends whole batches.
    for (int p = 0; p < 10; p++) begin
      if (p < 4) begin
        tx_idle = 32; rx_idle = 60;
      end else if (p < 7) begin
        tx_idle = 60; rx_idle = 32;
      end else begin
        tx_idle = 0; rx_idle = 0;
      end
      write_reg(REG_MODULATION, (p < 8) ? 7'(p) : 7'($urandom));
      write_reg(REG_WINDOW_LENGTH, (p == 9) ? 7'($urandom) : 7'(win_plan[p]));
      if (p == 7) hold_req = 1;
      n = 0;
      while (n < 80) begin
        len = $urandom_range(8, 1);
        grid = ($urandom_range(9) < 8);
        for (int s = 0; s < len; s++) begin
          send_symbol(pick_axis(grid), pick_axis(grid), s == len - 1);
          n++;
        end
      end
      drain();
    end

    // One long batch of full-scale symbols drives the largest errors.
    write_reg(REG_MODULATION, 7'd0);
    write_reg(REG_WINDOW_LENGTH, 7'd64);
    for (int s = 0; s < 100; s++)
      send_symbol(16'h8000, 16'h8000, s == 99);
    drain();

    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
